[hdl/lru_pkg.sv]
// Shared constants and types for the LRU page replacement core.
// Used by the interfaces, the frame cell, the top level and the checker.
package lru_pkg;

    localparam int FRAMES  = 16;
    localparam int PAGE_W  = 10;
    localparam int STAMP_W = 32;
    localparam int FAULT_W = 32;
    localparam int CFG_W   = 5;
    localparam int IDX_W   = 4;
    localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W   = $clog2(FRAMES + 1);

    localparam logic [CFG_W-1:0]   FRAMES_RESET = CFG_W'(16);
    localparam logic [STAMP_W-1:0] STAMP_MAX    = '1;
    localparam logic [FAULT_W-1:0] FAULT_MAX    = '1;

    // search word that walks down the row of frame cells
    typedef struct packed {
        logic               vld;
        logic [PAGE_W-1:0]  page;
        logic [CNT_W-1:0]   remain;
        logic               found;
        logic [FRAME_W-1:0] fslot;
        logic               have;
        logic [STAMP_W-1:0] best_stamp;
        logic [FRAME_W-1:0] best_slot;
        logic [PAGE_W-1:0]  best_page;
    } t_word;

    // update broadcast to the cells
    typedef struct packed {
        logic               en;
        logic               load;
        logic [FRAME_W-1:0] slot;
        logic [PAGE_W-1:0]  page;
        logic [STAMP_W-1:0] stamp;
    } t_wr;

endpackage

[hdl/lru_if.sv]
// Valid/ready channel interfaces of the LRU page replacement core.
// Depends on lru_pkg for field widths.
interface lru_in_if import lru_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page_id;

    modport source (output valid, output page_id, input ready);
    modport sink   (input valid, input page_id, output ready);
endinterface

interface lru_out_if import lru_pkg::*; ;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [IDX_W-1:0]   frame_index;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_count;

    modport source (output valid, output hit, output frame_index, output evicted_page,
                    output fault_count, input ready);
    modport sink   (input valid, input hit, input frame_index, input evicted_page,
                    input fault_count, output ready);
endinterface

interface lru_cfg_if import lru_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/lru_cell.sv]
// One frame cell: holds a frame's page and stamp, folds them into the passing
// search word and registers it for the next cell. Depends on lru_pkg.
module lru_cell import lru_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [FRAME_W-1:0] i_idx,
    input  t_word              i_word,
    input  t_wr                i_wr,
    output t_word              o_word
);

    logic [PAGE_W-1:0]  r_page;
    logic [STAMP_W-1:0] r_stamp;
    t_word              r_word;
    t_word              n_word;

    always_comb begin
        n_word = i_word;
        if (i_word.vld && i_word.remain != '0) begin
            n_word.remain = i_word.remain - CNT_W'(1);
            if (!i_word.found && r_page == i_word.page) begin
                n_word.found = 1'b1;
                n_word.fslot = i_idx;
            end
            // strict compare keeps the lowest frame on a tie
            if (!i_word.have || r_stamp < i_word.best_stamp) begin
                n_word.have       = 1'b1;
                n_word.best_stamp = r_stamp;
                n_word.best_slot  = i_idx;
                n_word.best_page  = r_page;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
            r_page     <= '0;
            r_stamp    <= '0;
        end else begin
            r_word <= n_word;
            if (i_wr.en && i_wr.slot == i_idx) begin
                if (i_wr.load) begin
                    r_page <= i_wr.page;
                end
                r_stamp <= i_wr.stamp;
            end
        end
    end

    assign o_word = r_word;

endmodule

[hdl/lru_page_replacement_core.sv]
// LRU page replacement core, time-stamp method: top level with control.
// Depends on lru_pkg, the channel interfaces and lru_cell.

// One page reference goes in per word and one result comes out. For each
// reference a search word walks the row of frame cells, one cell per cycle,
// collecting the matching frame and the oldest stamp; then, once the output
// register is free, the chosen frame is written and the result register loaded.
// Page 0 changes nothing. A finished result waits in the
// output register while the next reference is scanned. frames_in_use may be
// written at any time the core is idle; 0 acts as 1 and values above the frame
// count act as the frame count. No clearing pass is needed after reset.
module lru_page_replacement_core import lru_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lru_cfg_if.sink    i_cfg,
    lru_in_if.sink     i_in,
    lru_out_if.source  o_res
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_frames;
    logic [STAMP_W-1:0] r_clock;
    logic [FAULT_W-1:0] r_faults;
    t_word              r_head;
    t_word              r_res;
    logic               r_zero;
    logic               r_ovalid;
    logic               r_hit;
    logic [IDX_W-1:0]   r_fidx;
    logic [PAGE_W-1:0]  r_evict;
    logic [FAULT_W-1:0] r_fcnt;

    t_word              w_chain [FRAMES+1];
    t_wr                w_wr;
    logic [CNT_W-1:0]   w_nact;
    logic [FAULT_W-1:0] n_faults;
    logic               w_fire;

    assign w_chain[0] = r_head;

    for (genvar k = 0; k < FRAMES; k++) begin : g_cell
        lru_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (FRAME_W'(k)),
            .i_word  (w_chain[k]),
            .i_wr    (w_wr),
            .o_word  (w_chain[k+1])
        );
    end

    always_comb begin
        if (r_frames == '0) begin
            w_nact = CNT_W'(1);
        end else if (32'(r_frames) > FRAMES) begin
            w_nact = CNT_W'(FRAMES);
        end else begin
            w_nact = CNT_W'(r_frames);
        end
    end

    assign w_fire   = (r_state == S_FIN) && (!r_ovalid || o_res.ready);
    assign n_faults = (r_faults == FAULT_MAX) ? r_faults : r_faults + FAULT_W'(1);

    always_comb begin
        w_wr.en    = w_fire && !r_zero;
        w_wr.load  = !r_res.found;
        w_wr.slot  = r_res.found ? r_res.fslot : r_res.best_slot;
        w_wr.page  = r_res.page;
        w_wr.stamp = r_clock;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_frames <= FRAMES_RESET;
            r_clock  <= '0;
            r_faults <= '0;
            r_head   <= '0;
            r_zero   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_frames <= i_cfg.data;
            end
            if (r_ovalid && o_res.ready && !w_fire) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        if (i_in.page_id == '0) begin
                            r_zero  <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_zero <= 1'b0;
                            if (r_clock != STAMP_MAX) begin
                                r_clock <= r_clock + STAMP_W'(1);
                            end
                            r_head.vld        <= 1'b1;
                            r_head.page       <= i_in.page_id;
                            r_head.remain     <= w_nact;
                            r_head.found      <= 1'b0;
                            r_head.fslot      <= '0;
                            r_head.have       <= 1'b0;
                            r_head.best_stamp <= '0;
                            r_head.best_slot  <= '0;
                            r_head.best_page  <= '0;
                            r_state           <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // the head word enters cell 0 once, on the first scan cycle
                    r_head.vld <= 1'b0;
                    if (w_chain[FRAMES].vld) begin
                        r_res   <= w_chain[FRAMES];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_fire) begin
                        r_ovalid <= 1'b1;
                        if (r_zero) begin
                            r_hit   <= 1'b1;
                            r_fidx  <= '0;
                            r_evict <= '0;
                            r_fcnt  <= r_faults;
                        end else if (r_res.found) begin
                            r_hit   <= 1'b1;
                            r_fidx  <= IDX_W'(w_wr.slot);
                            r_evict <= '0;
                            r_fcnt  <= r_faults;
                        end else begin
                            r_hit    <= 1'b0;
                            r_fidx   <= IDX_W'(w_wr.slot);
                            r_evict  <= r_res.best_page;
                            r_fcnt   <= n_faults;
                            r_faults <= n_faults;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_cfg.ready        = 1'b1;
    assign i_in.ready         = (r_state == S_IDLE);
    assign o_res.valid        = r_ovalid;
    assign o_res.hit          = r_hit;
    assign o_res.frame_index  = r_fidx;
    assign o_res.evicted_page = r_evict;
    assign o_res.fault_count  = r_fcnt;

endmodule

[hdl/lru_chk.sv]
// Port-level checks for the LRU page replacement core, bound to the top level.
// Depends on lru_pkg for field widths.
module lru_chk import lru_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_hit,
    input logic [PAGE_W-1:0]  i_evicted,
    input logic [FAULT_W-1:0] i_faults
);

    // the result valid flag and fault count hold while the sink stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_faults))
        else $error("result word changed while stalled");

    // a hit never reports an evicted page
    a_hit_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_hit |-> i_evicted == '0)
        else $error("hit with evicted page");

    // a fault result counts at least itself
    a_fault_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_hit |-> i_faults != '0)
        else $error("fault with zero fault count");

    // one reference at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while busy");

endmodule

bind lru_page_replacement_core lru_chk u_lru_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_hit       (o_res.hit),
    .i_evicted   (o_res.evicted_page),
    .i_faults    (o_res.fault_count)
);
